// File: sv/tlc_pkg.sv
// ----------------------------------------------------------------------------
// tlc_pkg
// Types, codes and helpers shared by the two-way traffic light controller.
// ----------------------------------------------------------------------------
package tlc_pkg;

   // Request codes
   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_TOGGLE = 2'd1;
   localparam logic [1:0] REQ_BUTTON = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_WEST_GREEN  = 2'd0;
   localparam logic [1:0] CSR_SOUTH_GREEN = 2'd1;
   localparam logic [1:0] CSR_YELLOW      = 2'd2;

   // Reset values of the configuration registers
   localparam logic [6:0] WEST_GREEN_RESET  = 7'd20;
   localparam logic [6:0] SOUTH_GREEN_RESET = 7'd12;
   localparam logic [3:0] YELLOW_RESET      = 4'd3;

   // Lamp patterns: bit0 red, bit1 yellow, bit2 green
   localparam logic [2:0] LAMP_RED    = 3'b001;
   localparam logic [2:0] LAMP_YELLOW = 3'b010;
   localparam logic [2:0] LAMP_GREEN  = 3'b100;

   // Largest value the two-digit display can show
   localparam logic [7:0] DISPLAY_MAX = 8'd99;

   typedef enum logic [1:0] {
      PHASE_WEST_GREEN  = 2'd0,
      PHASE_WEST_YELLOW = 2'd1,
      PHASE_SOUTH_GREEN = 2'd2,
      PHASE_SOUTH_YELLOW = 2'd3
   } phase_type;

   typedef struct packed {
      logic [3:0] tens;
      logic [3:0] ones;
   } digits_type;

   // Split a value into decimal digits, saturating at 99
   function automatic digits_type to_digits(input logic [7:0] value);
      logic [7:0] v;
      logic [3:0] tens;
      logic [7:0] rem;
      digits_type d;
      v    = (value > DISPLAY_MAX) ? DISPLAY_MAX : value;
      tens = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (v >= 8'(10 * k)) begin
            tens = 4'(k);
         end
      end
      rem    = v - {1'b0, tens, 3'b000} - {3'b000, tens, 1'b0};
      d.tens = tens;
      d.ones = rem[3:0];
      return d;
   endfunction

endpackage

// File: sv/two_way_traffic_light_controller.sv
// ----------------------------------------------------------------------------
// two_way_traffic_light_controller
// Two-street traffic light with automatic cycling and manual button control.
// ----------------------------------------------------------------------------
// Each request (one-second tick, mode toggle or button sample) yields exactly
// one response carrying both streets' lamps, their countdowns as decimal
// digits and the mode. A request is taken every cycle while the response
// register is empty or being drained; its response is registered at
// acceptance, together with the controller state, and shown in the next
// cycle, so throughput is one request per cycle, limited only by how fast the
// response side takes results. Configuration writes take effect at the next
// countdown load; a yellow write also shifts the red street's shown count.
module two_way_traffic_light_controller
   import tlc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic       req_button_level,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_west_lamps,
   output logic [2:0] rsp_south_lamps,
   output logic [3:0] rsp_west_tens,
   output logic [3:0] rsp_west_ones,
   output logic [3:0] rsp_south_tens,
   output logic [3:0] rsp_south_ones,
   output logic       rsp_manual_active,
   // configuration port
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_wdata
);

   // Configuration registers
   logic [6:0] west_green_ff;
   logic [6:0] south_green_ff;
   logic [3:0] yellow_ff;

   // Controller state
   logic       manual_ff, manual_in;
   phase_type  phase_ff, phase_in;
   logic [6:0] seconds_left_ff, seconds_left_in;
   logic       running_ff, running_in;
   logic       last_button_ff, last_button_in;
   logic       await_release_ff, await_release_in;

   // Response register
   logic       rsp_valid_ff;
   logic [2:0] west_lamps_ff, west_lamps_in;
   logic [2:0] south_lamps_ff, south_lamps_in;
   digits_type west_digits_ff, west_digits_in;
   digits_type south_digits_ff, south_digits_in;

   logic       accept;
   logic [6:0] yellow_len;
   logic [6:0] west_len;
   logic [6:0] south_len;
   logic [6:0] next_len;
   logic [7:0] west_value;
   logic [7:0] south_value;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Lengths with zero read as one
   assign yellow_len = (yellow_ff == 4'd0) ? 7'd1 : {3'b000, yellow_ff};
   assign west_len   = (west_green_ff == 7'd0) ? 7'd1 : west_green_ff;
   assign south_len  = (south_green_ff == 7'd0) ? 7'd1 : south_green_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         west_green_ff  <= WEST_GREEN_RESET;
         south_green_ff <= SOUTH_GREEN_RESET;
         yellow_ff      <= YELLOW_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WEST_GREEN:  west_green_ff  <= csr_wdata;
            CSR_SOUTH_GREEN: south_green_ff <= csr_wdata;
            CSR_YELLOW:      yellow_ff      <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Next state for the request being taken
   always_comb begin
      manual_in        = manual_ff;
      phase_in         = phase_ff;
      seconds_left_in  = seconds_left_ff;
      running_in       = running_ff;
      last_button_in   = last_button_ff;
      await_release_in = await_release_ff;
      next_len         = yellow_len;

      unique case (phase_ff)
         PHASE_WEST_GREEN:  next_len = yellow_len;
         PHASE_WEST_YELLOW: next_len = south_len;
         PHASE_SOUTH_GREEN: next_len = yellow_len;
         default:           next_len = west_len;
      endcase

      unique case (req_type)
         REQ_TICK: begin
            if (!manual_ff) begin
               if (seconds_left_ff > 7'd1) begin
                  seconds_left_in = seconds_left_ff - 7'd1;
               end else begin
                  phase_in        = phase_type'(phase_ff + 2'd1);
                  seconds_left_in = next_len;
               end
            end else if (running_ff) begin
               if (seconds_left_ff > 7'd1) begin
                  seconds_left_in = seconds_left_ff - 7'd1;
               end else begin
                  phase_in = (phase_ff == PHASE_WEST_YELLOW) ? PHASE_SOUTH_GREEN
                                                             : PHASE_WEST_GREEN;
                  seconds_left_in = 7'd0;
                  running_in      = 1'b0;
               end
            end
         end
         REQ_TOGGLE: begin
            manual_in        = !manual_ff;
            running_in       = 1'b0;
            await_release_in = 1'b0;
            if (manual_ff) begin
               phase_in        = PHASE_WEST_GREEN;
               seconds_left_in = west_len;
            end
         end
         REQ_BUTTON: begin
            // falling edge of the select button starts a yellow countdown
            if (manual_ff && !running_ff && !await_release_ff &&
                last_button_ff && !req_button_level) begin
               phase_in = (phase_ff == PHASE_WEST_GREEN ||
                           phase_ff == PHASE_WEST_YELLOW) ? PHASE_WEST_YELLOW
                                                          : PHASE_SOUTH_YELLOW;
               seconds_left_in  = yellow_len;
               running_in       = 1'b1;
               await_release_in = 1'b1;
            end
            if (req_button_level) begin
               await_release_in = 1'b0;
            end
            last_button_in = req_button_level;
         end
         default: ;
      endcase
   end

   // Response values from the updated state
   always_comb begin
      west_value  = 8'd0;
      south_value = 8'd0;
      if (!manual_in) begin
         if (phase_in == PHASE_WEST_GREEN) begin
            west_value  = {1'b0, seconds_left_in};
            south_value = {1'b0, seconds_left_in} + {1'b0, yellow_len};
         end else if (phase_in == PHASE_SOUTH_GREEN) begin
            west_value  = {1'b0, seconds_left_in} + {1'b0, yellow_len};
            south_value = {1'b0, seconds_left_in};
         end else begin
            west_value  = {1'b0, seconds_left_in};
            south_value = {1'b0, seconds_left_in};
         end
      end else if (running_in) begin
         west_value  = {1'b0, seconds_left_in};
         south_value = {1'b0, seconds_left_in};
      end

      unique case (phase_in)
         PHASE_WEST_GREEN: begin
            west_lamps_in  = LAMP_GREEN;
            south_lamps_in = LAMP_RED;
         end
         PHASE_WEST_YELLOW: begin
            west_lamps_in  = LAMP_YELLOW;
            south_lamps_in = LAMP_RED;
         end
         PHASE_SOUTH_GREEN: begin
            west_lamps_in  = LAMP_RED;
            south_lamps_in = LAMP_GREEN;
         end
         default: begin
            west_lamps_in  = LAMP_RED;
            south_lamps_in = LAMP_YELLOW;
         end
      endcase

      west_digits_in  = to_digits(west_value);
      south_digits_in = to_digits(south_value);
   end

   // Advance the controller state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         manual_ff        <= 1'b0;
         phase_ff         <= PHASE_WEST_GREEN;
         seconds_left_ff  <= WEST_GREEN_RESET;
         running_ff       <= 1'b0;
         last_button_ff   <= 1'b1;
         await_release_ff <= 1'b0;
      end else if (accept) begin
         manual_ff        <= manual_in;
         phase_ff         <= phase_in;
         seconds_left_ff  <= seconds_left_in;
         running_ff       <= running_in;
         last_button_ff   <= last_button_in;
         await_release_ff <= await_release_in;
      end
   end

   // Hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         west_lamps_ff   <= west_lamps_in;
         south_lamps_ff  <= south_lamps_in;
         west_digits_ff  <= west_digits_in;
         south_digits_ff <= south_digits_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_west_lamps    = west_lamps_ff;
   assign rsp_south_lamps   = south_lamps_ff;
   assign rsp_west_tens     = west_digits_ff.tens;
   assign rsp_west_ones     = west_digits_ff.ones;
   assign rsp_south_tens    = south_digits_ff.tens;
   assign rsp_south_ones    = south_digits_ff.ones;
   assign rsp_manual_active = manual_ff;

   // Automatic mode never runs with an empty countdown
   a_auto_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      !manual_ff |-> seconds_left_ff != 7'd0)
      else $error("automatic mode with zero countdown");

   // A manual countdown only runs in manual mode on a yellow phase
   a_countdown_yellow: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> manual_ff &&
         (phase_ff == PHASE_WEST_YELLOW || phase_ff == PHASE_SOUTH_YELLOW))
      else $error("countdown running outside manual yellow");

   // A toggle request flips the reported mode
   a_toggle_flips: assert property (@(posedge clock) disable iff (reset)
      accept && req_type == REQ_TOGGLE |=> rsp_manual_active != $past(manual_ff))
      else $error("toggle did not switch mode");

   // Each street shows exactly one lamp
   a_one_lamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_west_lamps) && $onehot(rsp_south_lamps))
      else $error("lamp pattern not one-hot");

endmodule

// File: tb/two_way_traffic_light_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_way_traffic_light_controller_tb
// Self-checking bench for the two-way traffic light controller.
// ----------------------------------------------------------------------------
// Requests (ticks, mode toggles, button samples and the unused code) are sent
// over the valid/ready request channel. Each accepted request advances a
// behavioural model of the controller kept in this bench, and the lamps,
// digits and mode it predicts are queued. Every response is checked against
// the oldest queued view. Directed tests cover power-on state, register
// extremes, display saturation and the manual button rules; random traffic
// then runs automatic cycles and manual sequences under several register
// settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module two_way_traffic_light_controller_tb;
   import tlc_pkg::*;

   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam logic [1:0] CSR_UNUSED   = 2'd3;
   localparam logic       BTN_PRESSED  = 1'b0;
   localparam logic       BTN_RELEASED = 1'b1;
   localparam int         CYCLE_LIMIT     = 400000;
   localparam int         DRAIN_CYCLES    = 4;
   localparam int         RANDOM_PHASES   = 12;
   localparam int         ITEMS_PER_PHASE = 125;
   localparam int         MAX_REPORTS     = 10;

   // What the controller shows after one request
   typedef struct packed {
      logic [2:0] west_lamps;
      logic [2:0] south_lamps;
      logic [3:0] west_tens;
      logic [3:0] west_ones;
      logic [3:0] south_tens;
      logic [3:0] south_ones;
      logic       manual;
   } lights_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_type;
   logic       req_button_level;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [2:0] rsp_west_lamps;
   logic [2:0] rsp_south_lamps;
   logic [3:0] rsp_west_tens;
   logic [3:0] rsp_west_ones;
   logic [3:0] rsp_south_tens;
   logic [3:0] rsp_south_ones;
   logic       rsp_manual_active;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [6:0] csr_wdata;

   // Controller state and registers as the bench expects them
   logic       ctl_manual;
   phase_type  ctl_phase;
   logic [6:0] ctl_left;
   logic       ctl_running;
   logic       ctl_last_button;
   logic       ctl_await_release;
   logic [6:0] cfg_west_green;
   logic [6:0] cfg_south_green;
   logic [3:0] cfg_yellow;

   lights_type pending_views[$];
   int         cycle_count = 0;
   int         mismatches = 0;
   int         responses_checked = 0;
   int         sent_count = 0;
   int         tick_count = 0;
   int         toggle_count = 0;
   int         button_count = 0;
   int         register_writes = 0;
   int         hold_off_cycles = 0;
   bit         req_gaps_on = 1'b1;
   bit         rsp_stalls_on = 1'b1;

   two_way_traffic_light_controller u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_button_level  (req_button_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_west_lamps    (rsp_west_lamps),
      .rsp_south_lamps   (rsp_south_lamps),
      .rsp_west_tens     (rsp_west_tens),
      .rsp_west_ones     (rsp_west_ones),
      .rsp_south_tens    (rsp_south_tens),
      .rsp_south_ones    (rsp_south_ones),
      .rsp_manual_active (rsp_manual_active),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Count cycles and stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d responses still awaited",
               cycle_count, pending_views.size());
      $display("CHECKS FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Behavioural model of the controller
   // ------------------------------------------------------------------------
   function automatic logic [6:0] at_least_one(input logic [6:0] value);
      return (value == 7'd0) ? 7'd1 : value;
   endfunction

   function automatic logic [6:0] phase_length(input phase_type p);
      case (p)
         PHASE_WEST_GREEN:  return at_least_one(cfg_west_green);
         PHASE_SOUTH_GREEN: return at_least_one(cfg_south_green);
         default:           return at_least_one({3'b000, cfg_yellow});
      endcase
   endfunction

   // Two decimal digits, saturating at 99
   function automatic logic [7:0] as_digits(input int value);
      int v;
      v = (value > 99) ? 99 : value;
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   function automatic void restore_power_on();
      cfg_west_green    = WEST_GREEN_RESET;
      cfg_south_green   = SOUTH_GREEN_RESET;
      cfg_yellow        = YELLOW_RESET;
      ctl_manual        = 1'b0;
      ctl_phase         = PHASE_WEST_GREEN;
      ctl_left          = WEST_GREEN_RESET;
      ctl_running       = 1'b0;
      ctl_last_button   = BTN_RELEASED;
      ctl_await_release = 1'b0;
   endfunction

   // Advance the model by one request and return what should be shown
   function automatic lights_type apply_request(input logic [1:0] kind, input logic level);
      lights_type v;
      logic [6:0] y;
      int         west_val;
      int         south_val;
      west_val  = 0;
      south_val = 0;
      case (kind)
         REQ_TICK: begin
            if (!ctl_manual) begin
               if (ctl_left > 7'd1) begin
                  ctl_left = ctl_left - 7'd1;
               end else begin
                  ctl_phase = phase_type'(ctl_phase + 2'd1);
                  ctl_left  = phase_length(ctl_phase);
               end
            end else if (ctl_running) begin
               if (ctl_left > 7'd1) begin
                  ctl_left = ctl_left - 7'd1;
               end else begin
                  // countdown over: right of way passes to the other street
                  ctl_phase   = (ctl_phase == PHASE_WEST_YELLOW) ? PHASE_SOUTH_GREEN
                                                                 : PHASE_WEST_GREEN;
                  ctl_left    = 7'd0;
                  ctl_running = 1'b0;
               end
            end
         end
         REQ_TOGGLE: begin
            ctl_manual        = ~ctl_manual;
            ctl_running       = 1'b0;
            ctl_await_release = 1'b0;
            if (!ctl_manual) begin
               ctl_phase = PHASE_WEST_GREEN;
               ctl_left  = phase_length(PHASE_WEST_GREEN);
            end
         end
         REQ_BUTTON: begin
            // a falling edge starts a yellow countdown on the street with right of way
            if (ctl_manual && !ctl_running && !ctl_await_release &&
                ctl_last_button == BTN_RELEASED && level == BTN_PRESSED) begin
               ctl_phase = (ctl_phase == PHASE_WEST_GREEN || ctl_phase == PHASE_WEST_YELLOW)
                           ? PHASE_WEST_YELLOW : PHASE_SOUTH_YELLOW;
               ctl_left          = at_least_one({3'b000, cfg_yellow});
               ctl_running       = 1'b1;
               ctl_await_release = 1'b1;
            end
            if (level == BTN_RELEASED) begin
               ctl_await_release = 1'b0;
            end
            ctl_last_button = level;
         end
         default: ;
      endcase

      y = at_least_one({3'b000, cfg_yellow});
      if (!ctl_manual) begin
         west_val  = int'(ctl_left);
         south_val = int'(ctl_left);
         if (ctl_phase == PHASE_WEST_GREEN) begin
            south_val = int'(ctl_left) + int'(y);
         end else if (ctl_phase == PHASE_SOUTH_GREEN) begin
            west_val = int'(ctl_left) + int'(y);
         end
      end else if (ctl_running) begin
         west_val  = int'(ctl_left);
         south_val = int'(ctl_left);
      end

      case (ctl_phase)
         PHASE_WEST_GREEN:  begin v.west_lamps = LAMP_GREEN;  v.south_lamps = LAMP_RED; end
         PHASE_WEST_YELLOW: begin v.west_lamps = LAMP_YELLOW; v.south_lamps = LAMP_RED; end
         PHASE_SOUTH_GREEN: begin v.west_lamps = LAMP_RED;    v.south_lamps = LAMP_GREEN; end
         default:           begin v.west_lamps = LAMP_RED;    v.south_lamps = LAMP_YELLOW; end
      endcase
      {v.west_tens, v.west_ones}   = as_digits(west_val);
      {v.south_tens, v.south_ones} = as_digits(south_val);
      v.manual = ctl_manual;
      return v;
   endfunction

   function automatic string show(input lights_type v);
      return $sformatf("west %b %0d%0d south %b %0d%0d manual %b", v.west_lamps,
                       v.west_tens, v.west_ones, v.south_lamps, v.south_tens,
                       v.south_ones, v.manual);
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [6:0] pick_green();
      case ($urandom_range(0, 9))
         0:       return 7'd0;
         1:       return 7'h7F;
         2:       return 7'd90;
         default: return 7'($urandom_range(1, 8));
      endcase
   endfunction

   // Upper bits of the yellow write are junk the block must drop
   function automatic logic [6:0] pick_yellow();
      case ($urandom_range(0, 9))
         0:       return 7'd0;
         1:       return 7'h7F;
         2:       return 7'd9;
         default: return {3'($urandom), 4'($urandom_range(1, 4))};
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------------
   // Offer one request and hold it until the controller takes it
   task automatic send_request(input logic [1:0] kind, input logic level);
      int gap;
      gap = req_gaps_on ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_button_level <= level;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_views.push_back(apply_request(kind, level));
      sent_count++;
      case (kind)
         REQ_TICK:   tick_count++;
         REQ_TOGGLE: toggle_count++;
         REQ_BUTTON: button_count++;
         default: ;
      endcase
   endtask

   task automatic write_register(input logic [1:0] index, input logic [6:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_WEST_GREEN:  cfg_west_green  = value;
         CSR_SOUTH_GREEN: cfg_south_green = value;
         CSR_YELLOW:      cfg_yellow      = value[3:0];
         default: ;
      endcase
      register_writes++;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid and wait until every response is in
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_lengths(input logic [6:0] west, input logic [6:0] south,
                                input logic [6:0] yellow);
      write_register(CSR_WEST_GREEN, west);
      write_register(CSR_SOUTH_GREEN, south);
      write_register(CSR_YELLOW, yellow);
   endtask

   // Response side: random stalls, plus a long hold-off on demand
   initial begin : response_pacing
      int n;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            n = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (idle_length() + 1) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Check each response against the oldest expectation
   always @(posedge clock) begin : response_check
      lights_type seen;
      lights_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_west_lamps, rsp_south_lamps, rsp_west_tens, rsp_west_ones,
                  rsp_south_tens, rsp_south_ones, rsp_manual_active};
         if (pending_views.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected response at cycle %0d: %s", cycle_count, show(seen));
            end
         end else begin
            want = pending_views.pop_front();
            responses_checked++;
            if (seen.west_lamps !== want.west_lamps || seen.south_lamps !== want.south_lamps ||
                seen.west_tens !== want.west_tens || seen.west_ones !== want.west_ones ||
                seen.south_tens !== want.south_tens || seen.south_ones !== want.south_ones ||
                seen.manual !== want.manual) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("response %0d mismatch: expected %s, got %s",
                           responses_checked, show(want), show(seen));
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Observe the power-on state, including the unused request code
   task automatic test_power_on_state();
      send_request(REQ_UNUSED, BTN_PRESSED);
      send_request(REQ_UNUSED, BTN_RELEASED);
      send_request(REQ_TICK, BTN_RELEASED);
      send_request(REQ_TICK, BTN_PRESSED);
   endtask

   // Zero lengths load as one second; oversized lengths saturate the display
   task automatic test_register_extremes();
      drain_responses();
      write_lengths(7'd0, 7'd0, 7'd0);
      send_request(REQ_TOGGLE, BTN_RELEASED);
      send_request(REQ_TOGGLE, BTN_RELEASED);
      repeat (4) send_request(REQ_TICK, BTN_RELEASED);
      drain_responses();
      write_register(CSR_UNUSED, 7'h7F);
      write_lengths(7'h7F, 7'd90, 7'h7F);
      send_request(REQ_TOGGLE, BTN_PRESSED);
      send_request(REQ_TOGGLE, BTN_RELEASED);
      send_request(REQ_TICK, BTN_RELEASED);
      send_request(REQ_TICK, BTN_RELEASED);
   endtask

   // Button edges, ignored presses, countdown hand-over and a cut-short countdown
   task automatic test_manual_control();
      drain_responses();
      write_lengths(7'd4, 7'd3, 7'd2);
      send_request(REQ_BUTTON, BTN_PRESSED);    // sampled in automatic mode
      send_request(REQ_TOGGLE, BTN_RELEASED);
      send_request(REQ_BUTTON, BTN_PRESSED);    // no edge: still held
      send_request(REQ_TICK, BTN_RELEASED);     // idle in manual: ignored
      send_request(REQ_BUTTON, BTN_RELEASED);
      send_request(REQ_BUTTON, BTN_PRESSED);    // starts west yellow
      send_request(REQ_BUTTON, BTN_PRESSED);
      send_request(REQ_BUTTON, BTN_RELEASED);
      send_request(REQ_BUTTON, BTN_PRESSED);    // during countdown: ignored
      send_request(REQ_BUTTON, BTN_RELEASED);
      send_request(REQ_TICK, BTN_PRESSED);
      send_request(REQ_TICK, BTN_RELEASED);     // south gets green
      send_request(REQ_BUTTON, BTN_PRESSED);    // starts south yellow
      send_request(REQ_TOGGLE, BTN_PRESSED);    // cut short, restart at west green
      send_request(REQ_UNUSED, BTN_PRESSED);
   endtask

   // Hold the response side off while requests keep coming
   task automatic test_backpressure();
      drain_responses();
      req_gaps_on     = 1'b0;
      hold_off_cycles = 64;
      repeat (24) send_request(2'($urandom_range(0, 2)), 1'($urandom));
      req_gaps_on = 1'b1;
   endtask

   // One burst of traffic: automatic run, manual sequence or noise
   task automatic run_episode();
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            if (ctl_manual) send_request(REQ_TOGGLE, 1'($urandom));
            n = $urandom_range(1, 30);
            repeat (n) send_request(REQ_TICK, 1'($urandom));
         end
         4, 5, 6, 7: begin
            if (!ctl_manual) send_request(REQ_TOGGLE, 1'($urandom));
            repeat ($urandom_range(1, 3)) begin
               send_request(REQ_BUTTON, BTN_PRESSED);
               if ($urandom_range(0, 3) == 0) send_request(REQ_BUTTON, BTN_PRESSED);
               send_request(REQ_BUTTON, BTN_RELEASED);
               n = $urandom_range(1, int'(cfg_yellow) + 2);
               repeat (n) send_request(REQ_TICK, 1'($urandom));
            end
            if ($urandom_range(0, 1) == 1) send_request(REQ_TOGGLE, 1'($urandom));
         end
         default: begin
            repeat ($urandom_range(1, 6)) send_request(2'($urandom), 1'($urandom));
         end
      endcase
   endtask

   // Random traffic under a run of register settings, extremes first
   task automatic test_random_traffic();
      int target;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_responses();
         if (p == 0) begin
            write_lengths(7'd1, 7'd1, 7'd1);
         end else if (p == 1) begin
            write_lengths(7'd90, 7'd90, 7'd9);
         end else begin
            if ($urandom_range(0, 3) == 0) write_register(CSR_UNUSED, 7'($urandom));
            write_lengths(pick_green(), pick_green(), pick_yellow());
         end
         req_gaps_on   = (p % 3 != 2);
         rsp_stalls_on = (p % 4 != 3);
         target = sent_count + ITEMS_PER_PHASE;
         while (sent_count < target) run_episode();
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin : test_sequence
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_type         <= REQ_TICK;
      req_button_level <= BTN_RELEASED;
      csr_we           <= 1'b0;
      csr_index        <= CSR_WEST_GREEN;
      csr_wdata        <= 7'd0;
      restore_power_on();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_power_on_state();
      test_register_extremes();
      test_manual_control();
      test_backpressure();
      test_random_traffic();
      drain_responses();

      $display("sent %0d requests (%0d ticks, %0d toggles, %0d button samples)",
               sent_count, tick_count, toggle_count, button_count);
      $display("checked %0d responses over %0d register writes in %0d cycles",
               responses_checked, register_writes, cycle_count);
      if (pending_views.size() != 0) begin
         $display("%0d responses never arrived", pending_views.size());
         mismatches += pending_views.size();
      end
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/tlc_pkg.sv
sv/two_way_traffic_light_controller.sv
tb/two_way_traffic_light_controller_tb.sv
